@@ rtl/ssp_pkg.sv @@
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared codes and types for the shortest-seek request picker.
// ----------------------------------------------------------------------------
`default_nettype none

package ssp_pkg;

  // Command codes on in_cmd.
  localparam logic [1:0] CMD_ADD      = 2'd0;
  localparam logic [1:0] CMD_DISPATCH = 2'd1;
  localparam logic [1:0] CMD_REMOVE   = 2'd2;

  // Result status codes on out_status.
  localparam logic [2:0] ST_ADDED      = 3'd0;
  localparam logic [2:0] ST_DISPATCHED = 3'd1;
  localparam logic [2:0] ST_EMPTY      = 3'd2;
  localparam logic [2:0] ST_FULL       = 3'd3;
  localparam logic [2:0] ST_REMOVED    = 3'd4;
  localparam logic [2:0] ST_NOTFOUND   = 3'd5;

  // Control of the nearest-entry scan unit.
  typedef struct packed {
    logic clear;
    logic sample;
  } scan_ctl_t;

endpackage

`default_nettype wire

@@ rtl/ssp_ram.sv @@
// ----------------------------------------------------------------------------
// ssp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/ssp_scan_unit.sv @@
// ----------------------------------------------------------------------------
// ssp_scan_unit
// Shared seek-distance unit: takes one table word per cycle while sampling,
// forms its distance to the head and keeps the nearest since the last clear.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_scan_unit #(
  parameter int SECTOR_BITS = 48,
  parameter int TAG_BITS    = 8,
  parameter int IDX_W       = 5
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire ssp_pkg::scan_ctl_t     ctl,
  input  wire logic [IDX_W-1:0]       idx,
  input  wire logic [SECTOR_BITS-1:0] sector,
  input  wire logic [TAG_BITS-1:0]    tag,
  input  wire logic [SECTOR_BITS-1:0] head,
  output logic      [IDX_W-1:0]       best_idx,
  output logic      [SECTOR_BITS-1:0] best_sector,
  output logic      [TAG_BITS-1:0]    best_tag
);

  logic                   have_r;
  logic [SECTOR_BITS-1:0] best_dist_r;
  logic [IDX_W-1:0]       best_idx_r;
  logic [SECTOR_BITS-1:0] best_sector_r;
  logic [TAG_BITS-1:0]    best_tag_r;

  logic [SECTOR_BITS:0]   diff;
  logic [SECTOR_BITS-1:0] seek_dist;
  logic                   take;

  always_comb begin
    diff = {1'b0, sector} - {1'b0, head};
    seek_dist = diff[SECTOR_BITS] ? (head - sector) : diff[SECTOR_BITS-1:0];
    // A strict compare keeps the earliest entry on equal distances.
    take = !have_r || (seek_dist < best_dist_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (ctl.clear) begin
      have_r <= 1'b0;
    end else if (ctl.sample) begin
      have_r <= 1'b1;
    end
    if (ctl.sample && take) begin
      best_dist_r   <= seek_dist;
      best_idx_r    <= idx;
      best_sector_r <= sector;
      best_tag_r    <= tag;
    end
  end

  assign best_idx    = best_idx_r;
  assign best_sector = best_sector_r;
  assign best_tag    = best_tag_r;

endmodule

`default_nettype wire

@@ rtl/shortest_seek_request_picker.sv @@
// ----------------------------------------------------------------------------
// shortest_seek_request_picker
// Pending disk request table with add, nearest-sector dispatch and remove.
// ----------------------------------------------------------------------------
// Add: result in the cycle after start, busy stays low (one word per cycle).
// Dispatch: scans the N pending entries through the shared distance unit,
//   picks the nearest, then compacts the table behind that entry k (counted
//   from 0). The single RAM read port makes both passes read one word at a
//   time.
// Remove: scans for the first entry k with the tag, then the same compaction;
//   replies not found after the last entry when no entry matches.
// Empty or full cases answer in the next cycle. The receiver cannot stall.
// Reset clears count, head and last-added positions; table RAM is not cleared.
`default_nettype none

module shortest_seek_request_picker #(
  parameter int QUEUE_DEPTH = 32,
  parameter int SECTOR_BITS = 48,
  parameter int TAG_BITS    = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [1:0]             in_cmd,
  input  wire logic [TAG_BITS-1:0]    in_req_tag,
  input  wire logic [SECTOR_BITS-1:0] in_req_sector,
  output logic                        out_valid,
  output logic      [2:0]             out_status,
  output logic      [TAG_BITS-1:0]    out_tag,
  output logic      [SECTOR_BITS-1:0] out_sector,
  output logic                        out_moving_right
);

  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W = SECTOR_BITS + TAG_BITS;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] ONE        = CNT_W'(1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_PICK, S_SHIFT} state_t;

  state_t                 state_r, state_nxt;
  logic                   is_remove_r, is_remove_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [SECTOR_BITS-1:0] head_r, head_nxt;
  logic [SECTOR_BITS-1:0] last_add_r, last_add_nxt;
  logic [CNT_W-1:0]       iss_r, iss_nxt;
  logic                   dv_r, dv_nxt;
  logic [CNT_W-1:0]       didx_r, didx_nxt;
  logic [2:0]             res_status_r, res_status_nxt;
  logic [TAG_BITS-1:0]    res_tag_r, res_tag_nxt;
  logic [SECTOR_BITS-1:0] res_sector_r, res_sector_nxt;
  logic                   res_right_r, res_right_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [2:0]             out_status_r, out_status_nxt;
  logic [TAG_BITS-1:0]    out_tag_r, out_tag_nxt;
  logic [SECTOR_BITS-1:0] out_sector_r, out_sector_nxt;
  logic                   out_right_r, out_right_nxt;

  logic                   ram_wr_en;
  logic [IDX_W-1:0]       ram_wr_addr;
  logic [ENTRY_W-1:0]     ram_wr_data;
  logic                   ram_rd_en;
  logic [IDX_W-1:0]       ram_rd_addr;
  logic [ENTRY_W-1:0]     ram_rd_data;
  logic [SECTOR_BITS-1:0] rd_sector;
  logic [TAG_BITS-1:0]    rd_tag;
  logic [CNT_W-1:0]       wr_pos;
  logic                   last_word;

  ssp_pkg::scan_ctl_t     scan_ctl;
  logic [IDX_W-1:0]       best_idx;
  logic [SECTOR_BITS-1:0] best_sector;
  logic [TAG_BITS-1:0]    best_tag;

  ssp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign rd_sector = ram_rd_data[ENTRY_W-1:TAG_BITS];
  assign rd_tag    = ram_rd_data[TAG_BITS-1:0];

  ssp_scan_unit #(
    .SECTOR_BITS (SECTOR_BITS),
    .TAG_BITS    (TAG_BITS),
    .IDX_W       (IDX_W)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (scan_ctl),
    .idx         (didx_r[IDX_W-1:0]),
    .sector      (rd_sector),
    .tag         (rd_tag),
    .head        (head_r),
    .best_idx    (best_idx),
    .best_sector (best_sector),
    .best_tag    (best_tag)
  );

  assign wr_pos    = didx_r - ONE;
  assign last_word = (didx_r == (count_r - ONE));

  always_comb begin
    state_nxt      = state_r;
    is_remove_nxt  = is_remove_r;
    count_nxt      = count_r;
    head_nxt       = head_r;
    last_add_nxt   = last_add_r;
    iss_nxt        = iss_r;
    dv_nxt         = dv_r;
    didx_nxt       = didx_r;
    res_status_nxt = res_status_r;
    res_tag_nxt    = res_tag_r;
    res_sector_nxt = res_sector_r;
    res_right_nxt  = res_right_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_tag_nxt    = out_tag_r;
    out_sector_nxt = out_sector_r;
    out_right_nxt  = out_right_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = count_r[IDX_W-1:0];
    ram_wr_data    = {in_req_sector, in_req_tag};
    ram_rd_en      = 1'b0;
    ram_rd_addr    = iss_r[IDX_W-1:0];
    scan_ctl       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_cmd)
            ssp_pkg::CMD_ADD: begin
              out_valid_nxt  = 1'b1;
              out_tag_nxt    = in_req_tag;
              out_sector_nxt = in_req_sector;
              if (count_r == FULL_COUNT) begin
                out_status_nxt = ssp_pkg::ST_FULL;
                out_right_nxt  = 1'b0;
              end else begin
                ram_wr_en      = 1'b1;
                count_nxt      = count_r + ONE;
                last_add_nxt   = in_req_sector;
                out_status_nxt = ssp_pkg::ST_ADDED;
                out_right_nxt  = (last_add_r <= in_req_sector);
              end
            end
            ssp_pkg::CMD_DISPATCH: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ssp_pkg::ST_EMPTY;
                out_tag_nxt    = '0;
                out_sector_nxt = '0;
                out_right_nxt  = 1'b0;
              end else begin
                state_nxt      = S_SCAN;
                is_remove_nxt  = 1'b0;
                iss_nxt        = '0;
                dv_nxt         = 1'b0;
                scan_ctl.clear = 1'b1;
              end
            end
            ssp_pkg::CMD_REMOVE: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ssp_pkg::ST_NOTFOUND;
                out_tag_nxt    = in_req_tag;
                out_sector_nxt = '0;
                out_right_nxt  = 1'b0;
              end else begin
                state_nxt     = S_SCAN;
                is_remove_nxt = 1'b1;
                iss_nxt       = '0;
                dv_nxt        = 1'b0;
                res_tag_nxt   = in_req_tag;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        // Each read is issued in the cycle before its word is used.
        if (iss_r < count_r) begin
          ram_rd_en = 1'b1;
          iss_nxt   = iss_r + ONE;
          dv_nxt    = 1'b1;
          didx_nxt  = iss_r;
        end else begin
          dv_nxt = 1'b0;
        end
        if (dv_r) begin
          if (is_remove_r) begin
            if (rd_tag == res_tag_r) begin
              res_status_nxt = ssp_pkg::ST_REMOVED;
              res_sector_nxt = rd_sector;
              res_right_nxt  = 1'b0;
              iss_nxt        = didx_r + ONE;
              dv_nxt         = 1'b0;
              state_nxt      = S_SHIFT;
            end else if (last_word) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ssp_pkg::ST_NOTFOUND;
              out_tag_nxt    = res_tag_r;
              out_sector_nxt = '0;
              out_right_nxt  = 1'b0;
              dv_nxt         = 1'b0;
              state_nxt      = S_IDLE;
            end
          end else begin
            scan_ctl.sample = 1'b1;
            if (last_word) begin
              dv_nxt    = 1'b0;
              state_nxt = S_PICK;
            end
          end
        end
      end

      S_PICK: begin
        res_status_nxt = ssp_pkg::ST_DISPATCHED;
        res_tag_nxt    = best_tag;
        res_sector_nxt = best_sector;
        res_right_nxt  = (head_r <= best_sector);
        head_nxt       = best_sector;
        iss_nxt        = CNT_W'(best_idx) + ONE;
        dv_nxt         = 1'b0;
        state_nxt      = S_SHIFT;
      end

      S_SHIFT: begin
        // Each later word moves down one place to close the gap.
        if (iss_r < count_r) begin
          ram_rd_en = 1'b1;
          iss_nxt   = iss_r + ONE;
          dv_nxt    = 1'b1;
          didx_nxt  = iss_r;
        end else begin
          dv_nxt = 1'b0;
        end
        if (dv_r) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = wr_pos[IDX_W-1:0];
          ram_wr_data = ram_rd_data;
        end
        if (!(iss_r < count_r) && !dv_r) begin
          count_nxt      = count_r - ONE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_tag_nxt    = res_tag_r;
          out_sector_nxt = res_sector_r;
          out_right_nxt  = res_right_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      last_add_r  <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      last_add_r  <= last_add_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    is_remove_r  <= is_remove_nxt;
    iss_r        <= iss_nxt;
    didx_r       <= didx_nxt;
    res_status_r <= res_status_nxt;
    res_tag_r    <= res_tag_nxt;
    res_sector_r <= res_sector_nxt;
    res_right_r  <= res_right_nxt;
    out_status_r <= out_status_nxt;
    out_tag_r    <= out_tag_nxt;
    out_sector_r <= out_sector_nxt;
    out_right_r  <= out_right_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_tag          = out_tag_r;
  assign out_sector       = out_sector_r;
  assign out_moving_right = out_right_r;

endmodule

`default_nettype wire

@@ tb/tb_shortest_seek_request_picker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shortest_seek_request_picker
// Self-checking bench for the shortest-seek request picker. A scoreboard keeps
// its own copy of the pending request table, head position and last-added
// position, predicts the reply word for every accepted command, and compares
// each reply field by field. Directed words cover empty, tie, duplicate-tag
// and extreme-sector cases; random words alternate fill, drain and mixed
// traffic so the table regularly runs full and empty.
// ----------------------------------------------------------------------------
module tb_shortest_seek_request_picker;
  import ssp_pkg::*;

  localparam int DEPTH = 32;
  localparam int SEC_W = 48;
  localparam int TAG_W = 8;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [SEC_W-1:0] SEC_MAX = '1;
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_PRINTS = 40;

  typedef struct packed {
    logic [2:0]       status;
    logic [TAG_W-1:0] tag;
    logic [SEC_W-1:0] sector;
    logic             right;
  } reply_t;

  class seek_scoreboard;
    logic [SEC_W-1:0] sec_tbl[DEPTH];
    logic [TAG_W-1:0] tag_tbl[DEPTH];
    int               n_pending;
    logic [SEC_W-1:0] head_pos;
    logic [SEC_W-1:0] last_add_pos;
    reply_t           replies_due[$];
    int               errors;

    function new();
      n_pending = 0;
      head_pos = '0;
      last_add_pos = '0;
      errors = 0;
    endfunction

    function logic [SEC_W-1:0] seek_gap(input logic [SEC_W-1:0] a,
                                        input logic [SEC_W-1:0] b);
      return (a >= b) ? a - b : b - a;
    endfunction

    // Entries behind the removed one move up, keeping arrival order.
    function void drop_entry(input int idx);
      for (int i = idx; i + 1 < n_pending; i++) begin
        sec_tbl[i] = sec_tbl[i + 1];
        tag_tbl[i] = tag_tbl[i + 1];
      end
      n_pending--;
    endfunction

    function void log_command(input logic [1:0] c, input logic [TAG_W-1:0] t,
                              input logic [SEC_W-1:0] s);
      reply_t r;
      int best;
      int found;
      logic [SEC_W-1:0] d;
      logic [SEC_W-1:0] best_d;
      case (c)
        CMD_ADD: begin
          if (n_pending >= DEPTH) begin
            r = '{status: ST_FULL, tag: t, sector: s, right: 1'b0};
          end else begin
            r = '{status: ST_ADDED, tag: t, sector: s, right: last_add_pos <= s};
            sec_tbl[n_pending] = s;
            tag_tbl[n_pending] = t;
            n_pending++;
            last_add_pos = s;
          end
        end
        CMD_DISPATCH: begin
          if (n_pending == 0) begin
            r = '{status: ST_EMPTY, tag: '0, sector: '0, right: 1'b0};
          end else begin
            // Strict less-than keeps the earliest queued entry on a tie.
            best = 0;
            best_d = seek_gap(sec_tbl[0], head_pos);
            for (int i = 1; i < n_pending; i++) begin
              d = seek_gap(sec_tbl[i], head_pos);
              if (d < best_d) begin
                best = i;
                best_d = d;
              end
            end
            r = '{status: ST_DISPATCHED, tag: tag_tbl[best], sector: sec_tbl[best],
                  right: head_pos <= sec_tbl[best]};
            head_pos = sec_tbl[best];
            drop_entry(best);
          end
        end
        CMD_REMOVE: begin
          found = -1;
          for (int i = 0; i < n_pending; i++) begin
            if (found < 0 && tag_tbl[i] == t) found = i;
          end
          if (found < 0) begin
            r = '{status: ST_NOTFOUND, tag: t, sector: '0, right: 1'b0};
          end else begin
            r = '{status: ST_REMOVED, tag: t, sector: sec_tbl[found], right: 1'b0};
            drop_entry(found);
          end
        end
        default: return;
      endcase
      replies_due.push_back(r);
    endfunction

    task report(input string msg);
      if (errors < MAX_PRINTS) $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_reply(input reply_t got);
      reply_t want;
      if (replies_due.size() == 0) begin
        report($sformatf("unexpected reply word status %0d tag %0h", got.status, got.tag));
      end else begin
        want = replies_due.pop_front();
        if (got.status !== want.status)
          report($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.tag !== want.tag)
          report($sformatf("tag %0h, expected %0h", got.tag, want.tag));
        if (got.sector !== want.sector)
          report($sformatf("sector %0h, expected %0h", got.sector, want.sector));
        if (got.right !== want.right)
          report($sformatf("moving_right %0b, expected %0b", got.right, want.right));
      end
    endtask
  endclass

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [1:0]       in_cmd;
  logic [TAG_W-1:0] in_req_tag;
  logic [SEC_W-1:0] in_req_sector;
  logic             out_valid;
  logic [2:0]       out_status;
  logic [TAG_W-1:0] out_tag;
  logic [SEC_W-1:0] out_sector;
  logic             out_moving_right;

  seek_scoreboard sb;
  int idle_cycles;

  shortest_seek_request_picker #(
    .QUEUE_DEPTH(DEPTH),
    .SECTOR_BITS(SEC_W),
    .TAG_BITS(TAG_W)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_cmd(in_cmd),
    .in_req_tag(in_req_tag),
    .in_req_sector(in_req_sector),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_tag(out_tag),
    .out_sector(out_sector),
    .out_moving_right(out_moving_right)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_reply('{status: out_status, tag: out_tag, sector: out_sector,
                       right: out_moving_right});
    end
  end

  // Any accepted command or reply word counts as progress.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || (rst_n && out_valid)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("[shortest_seek_request_picker] ERROR");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input logic [1:0] c, input logic [TAG_W-1:0] t,
                           input logic [SEC_W-1:0] s, input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_cmd <= c;
    in_req_tag <= t;
    in_req_sector <= s;
    do @(posedge clk); while (busy);
    sb.log_command(c, t, s);
    @(negedge clk);
  endtask

  function automatic logic [SEC_W-1:0] pick_sector();
    int k;
    k = $urandom_range(0, 9);
    case (k)
      0: return '0;
      1: return SEC_MAX;
      2, 3, 4: return SEC_W'({$urandom(), $urandom()});
      5, 6: return sb.head_pos + SEC_W'($urandom_range(0, 4000)) - SEC_W'(2000);
      7: return sb.last_add_pos + SEC_W'($urandom_range(0, 16)) - SEC_W'(8);
      default: return sb.head_pos + SEC_W'($urandom_range(0, 8)) - SEC_W'(4);
    endcase
  endfunction

  // Traffic runs in stretches of fill, drain or mixed so the table swings
  // between full and empty.
  task automatic run_random(input int n_words, input int idle_pct);
    int sent;
    int mode_left;
    int r;
    int add_lim;
    int disp_lim;
    int rem_lim;
    logic [1:0] c;
    logic [TAG_W-1:0] t;
    sent = 0;
    mode_left = 0;
    add_lim = 45;
    disp_lim = 80;
    rem_lim = 96;
    while (sent < n_words) begin
      if (mode_left == 0) begin
        mode_left = 50;
        case ($urandom_range(0, 2))
          0: begin add_lim = 85; disp_lim = 93; rem_lim = 98; end
          1: begin add_lim = 20; disp_lim = 80; rem_lim = 96; end
          default: begin add_lim = 45; disp_lim = 80; rem_lim = 96; end
        endcase
      end
      mode_left--;
      r = $urandom_range(0, 99);
      t = TAG_W'($urandom());
      if (r < add_lim) c = CMD_ADD;
      else if (r < disp_lim) c = CMD_DISPATCH;
      else if (r < rem_lim) c = CMD_REMOVE;
      else c = CMD_UNUSED;
      // Removes mostly name a pending request; adds sometimes reuse a tag.
      if (sb.n_pending > 0 &&
          ((c == CMD_REMOVE && $urandom_range(0, 99) < 80) ||
           (c == CMD_ADD && $urandom_range(0, 99) < 15)))
        t = sb.tag_tbl[$urandom_range(0, sb.n_pending - 1)];
      send_word(c, t, pick_sector(), idle_pct);
      if (c != CMD_UNUSED) sent++;
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = CMD_ADD;
    in_req_tag = '0;
    in_req_sector = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_word(CMD_DISPATCH, 8'h00, '0, 20);
    send_word(CMD_REMOVE, 8'hA5, '0, 20);
    send_word(CMD_ADD, 8'h00, '0, 20);
    send_word(CMD_ADD, 8'hFF, SEC_MAX, 20);
    send_word(CMD_ADD, 8'h5A, 48'd1000, 20);
    send_word(CMD_ADD, 8'h11, 48'd1200, 20);
    send_word(CMD_ADD, 8'h22, 48'd800, 20);
    send_word(CMD_DISPATCH, 8'hFF, SEC_MAX, 20);
    send_word(CMD_DISPATCH, 8'h00, '0, 20);
    send_word(CMD_ADD, 8'h33, 48'd600, 20);
    send_word(CMD_ADD, 8'h44, 48'd1000, 20);
    // Head at 800: sectors 1000 and 600 are equally far, the older one wins.
    send_word(CMD_DISPATCH, 8'h00, '0, 20);
    send_word(CMD_DISPATCH, 8'h00, '0, 20);
    send_word(CMD_REMOVE, 8'hFF, '0, 20);
    send_word(CMD_REMOVE, 8'hFF, SEC_MAX, 20);
    send_word(CMD_ADD, 8'h11, 48'd1100, 20);
    send_word(CMD_REMOVE, 8'h11, '0, 20);
    send_word(CMD_UNUSED, 8'h7F, SEC_MAX, 20);
    send_word(CMD_DISPATCH, 8'h00, '0, 20);
    send_word(CMD_DISPATCH, 8'h00, '0, 20);
    send_word(CMD_DISPATCH, 8'h00, '0, 20);
    send_word(CMD_ADD, 8'h80, SEC_MAX, 20);
    send_word(CMD_DISPATCH, 8'h01, 48'h5555_5555_5555, 20);
    send_word(CMD_ADD, 8'h01, '0, 20);

    run_random(250, 36);
    run_random(250, 85);
    run_random(250, 0);
    start <= 1'b0;

    while (sb.replies_due.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 8) @(posedge clk);
    if (sb.errors == 0) $display("[shortest_seek_request_picker] OK");
    else $display("[shortest_seek_request_picker] ERROR");
    $finish;
  end

endmodule
